/* hw/rtl/kleb_pkg.sv */
// Shared key codes and controller/datapath interface types for the keypad line buffer.
package kleb_pkg;

	// Key codes with a special meaning, and the line terminator sent on enter
	localparam logic [7:0] KEY_BACKSPACE = 8'd8;
	localparam logic [7:0] KEY_ENTER     = 8'd13;
	localparam logic [7:0] CHAR_NEWLINE  = 8'd10;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic key_acc;    // key transfer this cycle: edit the line
		logic clr_ptr;    // restart the read pointer for a new line
		logic rd_en;      // read the line store at the read pointer
		logic load_char;  // load the stored character into the output register
		logic load_nl;    // load the newline item and empty the line
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic is_enter;   // key code on the input is enter
		logic at_end;     // read pointer has reached the fill count
		logic out_full;   // output register holds an item
		logic out_take;   // output item transfers this cycle
	} sts_t;

endpackage

/* hw/rtl/kleb_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
module kleb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* hw/rtl/kleb_ctrl.sv */
// Controller state machine: key intake and the read-out sequence of a line.
module kleb_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  kleb_pkg::sts_t sts,
	output kleb_pkg::cmd_t cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;  // taking keys
	localparam logic [1:0] ST_RD   = 2'd1;  // waiting for the output register, then read
	localparam logic [1:0] ST_LD   = 2'd2;  // load read data or the newline

	logic [1:0] state_q;
	logic [1:0] state_nxt;

	// Next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_stall  = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall    = 1'b0;
				cmd.key_acc = in_valid;
				if (in_valid && sts.is_enter) begin
					cmd.clr_ptr = 1'b1;
					state_nxt   = ST_RD;
				end
			end
			ST_RD: begin
				if (!sts.out_full || sts.out_take) begin
					cmd.rd_en = !sts.at_end;
					state_nxt = ST_LD;
				end
			end
			ST_LD: begin
				if (sts.at_end) begin
					cmd.load_nl = 1'b1;
					state_nxt   = ST_IDLE;
				end else begin
					cmd.load_char = 1'b1;
					state_nxt     = ST_RD;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

/* hw/rtl/kleb_dp.sv */
// Datapath: line store, fill count, read pointer and output register.
module kleb_dp #(
	parameter int LINE_DEPTH = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [7:0]     key_code,
	input  logic           out_stall,
	output logic           out_valid,
	output logic [7:0]     char_out,
	output logic           line_end,
	input  kleb_pkg::cmd_t cmd,
	output kleb_pkg::sts_t sts
);

	localparam int CW = $clog2(LINE_DEPTH + 1);
	localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

	logic [CW-1:0] count_q;
	logic [CW-1:0] ptr_q;
	logic [7:0]    char_q;
	logic          line_end_q;
	logic          out_valid_q;
	logic [7:0]    rdata;
	logic          is_bs;
	logic          is_enter;
	logic          full;
	logic          wr_en;
	logic          out_take;

	// Key decode
	assign is_bs    = (key_code == kleb_pkg::KEY_BACKSPACE);
	assign is_enter = (key_code == kleb_pkg::KEY_ENTER);
	assign full     = (count_q == CW'(LINE_DEPTH));
	assign wr_en    = cmd.key_acc && !is_bs && !is_enter && !full;
	assign out_take = out_valid_q && !out_stall;

	kleb_ram #(
		.WIDTH(8),
		.DEPTH(LINE_DEPTH)
	) u_line_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (count_q[AW-1:0]),
		.wdata (key_code),
		.re    (cmd.rd_en),
		.raddr (ptr_q[AW-1:0]),
		.rdata (rdata)
	);

	// Fill count: append, backspace, cleared once the newline is loaded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.load_nl) begin
			count_q <= '0;
		end else if (wr_en) begin
			count_q <= count_q + CW'(1);
		end else if (cmd.key_acc && is_bs && (count_q != '0)) begin
			count_q <= count_q - CW'(1);
		end
	end

	// Read pointer over the line being sent
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else if (cmd.clr_ptr) begin
			ptr_q <= '0;
		end else if (cmd.load_char) begin
			ptr_q <= ptr_q + CW'(1);
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_char || cmd.load_nl) begin
			out_valid_q <= 1'b1;
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (cmd.load_nl) begin
			char_q     <= kleb_pkg::CHAR_NEWLINE;
			line_end_q <= 1'b1;
		end else if (cmd.load_char) begin
			char_q     <= rdata;
			line_end_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign char_out  = char_q;
	assign line_end  = line_end_q;

	assign sts.is_enter = is_enter;
	assign sts.at_end   = (ptr_q == count_q);
	assign sts.out_full = out_valid_q;
	assign sts.out_take = out_take;

endmodule

/* hw/rtl/keypad_line_edit_buffer.sv */
// Top level of the keypad line buffer: controller, datapath and checks.
//
// Keys are taken one per cycle while no line is being sent: any key other than
// backspace and enter is appended (dropped when LINE_DEPTH characters are held),
// backspace removes the last character, and enter sends the held characters in
// order followed by a newline (10) with line_end set, then empties the line.
// Enter keeps in_stall high while the line is read out, and longer under
// output stall, because each character is one read of the line store
// (registered read) followed by one load of the output register, and the
// newline is one more load of the output register.
// The newline waits in the output register while new keys are already taken.
module keypad_line_edit_buffer #(
	parameter int LINE_DEPTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] key_code,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] char_out,
	output logic       line_end
);

	kleb_pkg::cmd_t cmd;
	kleb_pkg::sts_t sts;

	kleb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	kleb_dp #(
		.LINE_DEPTH(LINE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.key_code  (key_code),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.char_out  (char_out),
		.line_end  (line_end),
		.cmd       (cmd),
		.sts       (sts)
	);

`ifndef ASSERT_OFF
	// The line end item always carries the newline code
	a_line_end_nl: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && line_end) |-> (char_out == kleb_pkg::CHAR_NEWLINE))
		else $error("line end item without newline code");

	// An accepted enter blocks further keys while the line is read out
	a_enter_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && (key_code == kleb_pkg::KEY_ENTER)) |=> in_stall)
		else $error("key intake not stopped after enter");

	// Output items are only produced during a read-out
	a_out_from_readout: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("output item loaded outside a read-out");
`endif

endmodule
